// ----- hw/rtl/decimal_lsd_radix_sorter_core_macros.svh -----
// Assertion macros for the decimal radix sorter.
`ifndef DECIMAL_LSD_RADIX_SORTER_CORE_MACROS_SVH
`define DECIMAL_LSD_RADIX_SORTER_CORE_MACROS_SVH
// same-cycle implication
`define DRLS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("drls assertion failed");
// next-cycle implication
`define DRLS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("drls assertion failed");
`endif

// ----- hw/rtl/drls_pkg.sv -----
// Shared types and constants of the decimal radix sorter.
package drls_pkg;
	localparam int MAX_ITEMS   = 64;
	localparam int DIGIT_RANGE = 10;
	localparam int VAL_W       = 31;
	localparam int ADDR_W      = $clog2(MAX_ITEMS);
	localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
	localparam int DIG_W       = $clog2(DIGIT_RANGE);
	// reciprocal of ten, exact for operands below 2^32 with a shift of 35
	localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;
	localparam int RECIP_SH = 35;
	localparam int PROD_W   = VAL_W + 32;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             final_item;
	} in_beat_t;

	typedef struct packed {
		logic [VAL_W-1:0] sorted_value;
		logic             end_of_run;
	} out_beat_t;

	// stored entry: original value and its quotient by the current place
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [VAL_W-1:0] quot;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic              bank;
		logic [ADDR_W-1:0] addr;
		entry_t            data;
	} wr_req_t;
endpackage

// ----- hw/rtl/drls_div10.sv -----
// Shared divide-by-ten unit: reciprocal multiply, registered product.
module drls_div10 (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_vld,
	input  logic [drls_pkg::VAL_W-1:0] in_x,
	input  logic [drls_pkg::VAL_W-1:0] in_tag,
	output logic                      out_vld,
	output logic [drls_pkg::VAL_W-1:0] out_q,
	output logic [drls_pkg::DIG_W-1:0] out_r,
	output logic [drls_pkg::VAL_W-1:0] out_tag
);
	import drls_pkg::*;

	logic              vld_q;
	logic [PROD_W-1:0] prod_q;
	logic [VAL_W-1:0]  x_q;
	logic [VAL_W-1:0]  tag_q;
	logic [VAL_W-1:0]  q10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(in_x) * PROD_W'(RECIP10);
		x_q    <= in_x;
		tag_q  <= in_tag;
	end

	assign out_q   = VAL_W'(prod_q >> RECIP_SH);
	assign q10     = (out_q << 3) + (out_q << 1);
	assign out_r   = DIG_W'(x_q - q10);
	assign out_vld = vld_q;
	assign out_tag = tag_q;
endmodule

// ----- hw/rtl/drls_store.sv -----
// Ping-pong item store: two banks, one write and one registered read.
module drls_store (
	input  logic                       clk,
	input  drls_pkg::wr_req_t          wr,
	input  logic                       rd_bank,
	input  logic [drls_pkg::ADDR_W-1:0] rd_addr,
	output drls_pkg::entry_t           rd_data
);
	import drls_pkg::*;

	entry_t bank0_q [MAX_ITEMS];
	entry_t bank1_q [MAX_ITEMS];

	always_ff @(posedge clk) begin
		if (wr.en && !wr.bank) begin
			bank0_q[wr.addr] <= wr.data;
		end
		if (wr.en && wr.bank) begin
			bank1_q[wr.addr] <= wr.data;
		end
		rd_data <= rd_bank ? bank1_q[rd_addr] : bank0_q[rd_addr];
	end
endmodule

// ----- hw/rtl/decimal_lsd_radix_sorter_core.sv -----
// Top level of the decimal LSD radix sorter.
//
// Input channel (in_valid / in_stall / in_data): one value per beat, loaded
// one per cycle; a beat with final_item set closes the set and starts the
// sort. Beats beyond 64 held items are dropped (a dropped final beat still
// starts the sort). in_stall rises after the closing beat and stays high
// until the last result of the set has been taken.
// Sort: one pass per decimal digit of the largest value (none if it is 0).
// A pass reads the store once to count digits, forms prefix sums and reads
// it again back to front to scatter into the other bank, then steps the
// place through the divide unit.
// All digit work goes through one shared reciprocal divide-by-ten unit.
// Output channel (out_valid / out_stall / out_data): N result beats in
// ascending order, end_of_run on the last; a new beat is read only once
// the previous one is taken. A stalled beat holds in the output register.
// Up to ten passes, each with its check state; sort time is set by the
// sequential walk over the store.
// Reset empties the set; store contents need no clearing.
`include "decimal_lsd_radix_sorter_core_macros.svh"
module decimal_lsd_radix_sorter_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  drls_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output drls_pkg::out_beat_t out_data
);
	import drls_pkg::*;

	typedef enum logic [3:0] {
		S_LOAD, S_CHECK, S_COUNT, S_PREFIX, S_SCAT,
		S_DIVL, S_DIVLW, S_EISSUE, S_EWAIT, S_EHOLD
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  items_q;     // items held in the set
	logic [VAL_W-1:0]  largest_q;   // largest quotient left
	logic              src_q;       // bank holding current order
	logic [CNT_W-1:0]  iss_q;       // read issue index
	logic [DIG_W-1:0]  pidx_q;      // prefix-sum index
	logic [CNT_W-1:0]  dcnt_q [DIGIT_RANGE];
	logic              rd_vld_s1;
	out_beat_t         out_q;
	logic              out_vld_q;

	wr_req_t           wr;
	logic              rd_bank;
	logic [ADDR_W-1:0] rd_addr;
	entry_t            rd_data;
	logic              issue;

	logic              dv_in_vld;
	logic [VAL_W-1:0]  dv_in_x;
	logic [VAL_W-1:0]  dv_in_tag;
	logic              dv_vld;
	logic [VAL_W-1:0]  dv_q;
	logic [DIG_W-1:0]  dv_r;
	logic [VAL_W-1:0]  dv_tag;

	logic              in_acc;
	logic              room;
	logic [VAL_W-1:0]  new_largest;
	logic              pipe_idle;
	logic [CNT_W-1:0]  scat_pos;
	logic              last_beat;

	assign in_stall  = (state_q != S_LOAD);
	assign in_acc    = in_valid && !in_stall;
	assign room      = (items_q < CNT_W'(MAX_ITEMS));
	assign new_largest = (room && (in_data.value > largest_q)) ? in_data.value : largest_q;
	assign pipe_idle = !rd_vld_s1 && !dv_vld;
	assign scat_pos  = dcnt_q[dv_r] - CNT_W'(1);
	assign last_beat = (iss_q + CNT_W'(1) == items_q);

	// read issue: forward in counting, backward in scattering, single in emission
	always_comb begin
		issue   = 1'b0;
		rd_addr = ADDR_W'(iss_q);
		rd_bank = src_q;
		case (state_q)
			S_COUNT: begin
				issue = (iss_q != items_q);
			end
			S_SCAT: begin
				issue   = (iss_q != '0);
				rd_addr = ADDR_W'(iss_q - CNT_W'(1));
			end
			S_EISSUE: begin
				issue = 1'b1;
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	always_comb begin
		wr      = '0;
		wr.addr = ADDR_W'(items_q);
		wr.data = '{value: in_data.value, quot: in_data.value};
		if (in_acc && room) begin
			wr.en = 1'b1;
		end else if (state_q == S_SCAT && dv_vld) begin
			wr.en   = 1'b1;
			wr.bank = !src_q;
			wr.addr = ADDR_W'(scat_pos);
			wr.data = '{value: dv_tag, quot: dv_q};
		end
	end

	assign dv_in_vld = rd_vld_s1 || (state_q == S_DIVL);
	assign dv_in_x   = (state_q == S_DIVL) ? largest_q : rd_data.quot;
	assign dv_in_tag = rd_data.value;

	drls_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_bank (rd_bank),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	drls_div10 u_div10 (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (dv_in_vld),
		.in_x    (dv_in_x),
		.in_tag  (dv_in_tag),
		.out_vld (dv_vld),
		.out_q   (dv_q),
		.out_r   (dv_r),
		.out_tag (dv_tag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			items_q   <= '0;
			largest_q <= '0;
			src_q     <= 1'b0;
			iss_q     <= '0;
			pidx_q    <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
			out_q     <= '0;
			for (int i = 0; i < DIGIT_RANGE; i++) begin
				dcnt_q[i] <= '0;
			end
		end else begin
			rd_vld_s1 <= issue && (state_q != S_EISSUE);
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (room) begin
							items_q <= items_q + CNT_W'(1);
						end
						largest_q <= new_largest;
						if (in_data.final_item) begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					for (int i = 0; i < DIGIT_RANGE; i++) begin
						dcnt_q[i] <= '0;
					end
					iss_q <= '0;
					state_q <= (largest_q == '0) ? S_EISSUE : S_COUNT;
				end
				S_COUNT: begin
					if (issue) begin
						iss_q <= iss_q + CNT_W'(1);
					end
					if (dv_vld) begin
						dcnt_q[dv_r] <= dcnt_q[dv_r] + CNT_W'(1);
					end
					if (!issue && pipe_idle) begin
						pidx_q  <= DIG_W'(1);
						state_q <= S_PREFIX;
					end
				end
				S_PREFIX: begin
					dcnt_q[pidx_q] <= dcnt_q[pidx_q] + dcnt_q[pidx_q - DIG_W'(1)];
					pidx_q <= pidx_q + DIG_W'(1);
					if (pidx_q == DIG_W'(DIGIT_RANGE - 1)) begin
						iss_q   <= items_q;
						state_q <= S_SCAT;
					end
				end
				S_SCAT: begin
					if (issue) begin
						iss_q <= iss_q - CNT_W'(1);
					end
					if (dv_vld) begin
						dcnt_q[dv_r] <= scat_pos;
					end
					if (!issue && pipe_idle) begin
						src_q   <= !src_q;
						state_q <= S_DIVL;
					end
				end
				S_DIVL: begin
					state_q <= S_DIVLW;
				end
				S_DIVLW: begin
					largest_q <= dv_q;
					state_q   <= S_CHECK;
				end
				S_EISSUE: begin
					state_q <= S_EWAIT;
				end
				S_EWAIT: begin
					out_q     <= '{sorted_value: rd_data.value, end_of_run: last_beat};
					out_vld_q <= 1'b1;
					state_q   <= S_EHOLD;
				end
				S_EHOLD: begin
					if (!out_stall) begin
						out_vld_q <= 1'b0;
						if (out_q.end_of_run) begin
							items_q   <= '0;
							largest_q <= '0;
							src_q     <= 1'b0;
							state_q   <= S_LOAD;
						end else begin
							iss_q   <= iss_q + CNT_W'(1);
							state_q <= S_EISSUE;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	`DRLS_ASSERT_NOW(a_out_only_in_hold, out_vld_q, state_q == S_EHOLD)
	`DRLS_ASSERT_NOW(a_load_pipe_empty, !in_stall, pipe_idle)
	`DRLS_ASSERT_NOW(a_scat_in_range, state_q == S_SCAT && dv_vld, scat_pos < items_q)
	`DRLS_ASSERT_NXT(a_set_cleared, out_vld_q && !out_stall && out_q.end_of_run,
		items_q == '0 && state_q == S_LOAD)
endmodule

// ----- tb/sv/decimal_lsd_radix_sorter_core_tb.sv -----
// Testbench for the decimal LSD radix sorter core.
`timescale 1ns / 100ps
module decimal_lsd_radix_sorter_core_tb;
	import drls_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_beat_t out_data;

	decimal_lsd_radix_sorter_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	// stimulus beats waiting for the driver; a set drain_mark entry pauses the
	// sender after its beat until every expected result has come
	in_beat_t  pending_beats[$];
	bit        drain_mark[$];
	out_beat_t sorted_expected[$];

	// predictor state: values held in the current set and their maximum
	logic [VAL_W-1:0] held_values[$];
	logic [VAL_W-1:0] held_max;

	int  error_count;
	int  idle_cycles;
	bit  stim_done;
	int  in_gap;
	int  out_gap;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// one LSD pass per decimal digit of the largest value, counting sort, stable
	task automatic predict_sorted_run();
		logic [VAL_W-1:0] src[$];
		logic [VAL_W-1:0] dst[];
		int unsigned      counts[DIGIT_RANGE];
		longint unsigned  place;
		int               n;
		int               d;
		src = held_values;
		n = src.size();
		dst = new[n];
		place = 1;
		while (longint'(held_max) / place > 0) begin
			foreach (counts[i]) counts[i] = 0;
			for (int i = 0; i < n; i++) counts[(longint'(src[i]) / place) % 10]++;
			for (int i = 1; i < DIGIT_RANGE; i++) counts[i] += counts[i-1];
			for (int i = n - 1; i >= 0; i--) begin
				d = (longint'(src[i]) / place) % 10;
				counts[d]--;
				dst[counts[d]] = src[i];
			end
			for (int i = 0; i < n; i++) src[i] = dst[i];
			place *= 10;
		end
		for (int i = 0; i < n; i++)
			sorted_expected.push_back('{sorted_value: src[i], end_of_run: (i == n - 1)});
		held_values.delete();
		held_max = '0;
	endtask

	task automatic accept_into_model(in_beat_t b);
		if (held_values.size() < MAX_ITEMS) begin
			held_values.push_back(b.value);
			if (b.value > held_max) held_max = b.value;
		end
		if (b.final_item) predict_sorted_run();
	endtask

	// --- stimulus generation ---
	function automatic logic [VAL_W-1:0] rand_value();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return VAL_W'($urandom_range(0, 9));
			1: return VAL_W'($urandom_range(0, 999));
			2: return '1;
			3: return VAL_W'($urandom_range(0, 99999));
			default: return VAL_W'($urandom() & 32'h7FFF_FFFF);
		endcase
	endfunction

	task automatic add_set(int n, int mode);
		logic [VAL_W-1:0] v;
		for (int i = 0; i < n; i++) begin
			case (mode)
				1: v = VAL_W'($urandom_range(0, 3) * 10 ** $urandom_range(0, 9));
				2: v = '0;
				default: v = rand_value();
			endcase
			pending_beats.push_back('{value: v, final_item: (i == n - 1)});
			drain_mark.push_back(1'b0);
		end
	endtask

	initial begin
		int count;
		int n;
		// directed: lone zero, lone max, all zeros, single-digit set, extremes
		pending_beats.push_back('{value: '0, final_item: 1'b1});
		drain_mark.push_back(1'b0);
		pending_beats.push_back('{value: '1, final_item: 1'b1});
		drain_mark.push_back(1'b0);
		add_set(3, 2);
		pending_beats.push_back('{value: 31'd7, final_item: 1'b0});
		pending_beats.push_back('{value: 31'd3, final_item: 1'b0});
		pending_beats.push_back('{value: 31'd7, final_item: 1'b1});
		drain_mark.push_back(1'b0);
		drain_mark.push_back(1'b0);
		drain_mark.push_back(1'b0);
		pending_beats.push_back('{value: '1, final_item: 1'b0});
		pending_beats.push_back('{value: 31'h2AAA_AAAA, final_item: 1'b0});
		pending_beats.push_back('{value: 31'h5555_5555, final_item: 1'b0});
		pending_beats.push_back('{value: 31'd1000000000, final_item: 1'b0});
		pending_beats.push_back('{value: 31'd0, final_item: 1'b1});
		repeat (5) drain_mark.push_back(1'b0);
		count = pending_beats.size();
		// overflow set: store fills, extra beats and a dropped final beat
		add_set(70, 0);
		count += 70;
		// pause the sender until the pipe drains once
		drain_mark[drain_mark.size() - 1] = 1'b1;
		while (count < 380) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 66) : $urandom_range(1, 12);
			add_set(n, $urandom_range(0, 3) == 0 ? 1 : 0);
			count += n;
			if ($urandom_range(0, 19) == 0) drain_mark[drain_mark.size() - 1] = 1'b1;
		end
	end

	// --- driver ---
	bit hold_for_drain;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			in_gap   <= 0;
			hold_for_drain <= 1'b0;
			stim_done <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				accept_into_model(in_data);
				hold_for_drain <= drain_mark.pop_front();
				in_gap <= pick_gap();
				in_valid <= 1'b0;
				if (pending_beats.size() == 0) stim_done <= 1'b1;
			end else if (!in_valid) begin
				if (hold_for_drain) begin
					if (sorted_expected.size() == 0) hold_for_drain <= 1'b0;
				end else if (in_gap > 0) begin
					in_gap <= in_gap - 1;
				end else if (pending_beats.size() > 0) begin
					in_data  <= pending_beats.pop_front();
					in_valid <= 1'b1;
				end
			end
		end
	end

	// --- monitor and output stall ---
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap   <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (sorted_expected.size() == 0) begin
					$display("%0t: unexpected beat, actual %0d/%0b", $time,
						out_data.sorted_value, out_data.end_of_run);
					error_count++;
				end else begin
					out_beat_t exp_beat;
					exp_beat = sorted_expected.pop_front();
					if (exp_beat.sorted_value !== out_data.sorted_value) begin
						$display("%0t: sorted_value mismatch, expected %0d actual %0d", $time,
							exp_beat.sorted_value, out_data.sorted_value);
						error_count++;
					end
					if (exp_beat.end_of_run !== out_data.end_of_run) begin
						$display("%0t: end_of_run mismatch, expected %0b actual %0b", $time,
							exp_beat.end_of_run, out_data.end_of_run);
						error_count++;
					end
				end
			end
			// random stall: stretches without stall, short and rare long holds
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 3) == 0) out_gap <= pick_gap();
			end
		end
	end

	// watchdog: cycles with no beat accepted on either channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		error_count = 0;
		held_max = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		fork
			begin
				wait (stim_done && sorted_expected.size() == 0);
				repeat (100) @(posedge clk);
			end
			begin
				wait (idle_cycles >= WATCHDOG_LIMIT);
				error_count++;
				$display("%0t: watchdog expired, %0d beats still expected", $time,
					sorted_expected.size());
			end
		join_any
		if (error_count == 0 && sorted_expected.size() == 0)
			$display("[decimal_lsd_radix_sorter_core] OK");
		else
			$display("[decimal_lsd_radix_sorter_core] ERROR");
		$finish;
	end
endmodule
